FILE: rtl/pcxd_pkg.sv
// ----------------------------------------------------------------------------
// pcxd_pkg
// Shared types and constants of the PCX 8-bit run-length palette decoder:
// channel items, result codes, header offsets and the header parser status.
// ----------------------------------------------------------------------------
package pcxd_pkg;

  // default frame store size in pixels
  localparam int MAX_PIXELS_DEF = 65536;

  // header and palette sizes
  localparam int HDR_LEN = 128;
  localparam int PAL_LEN = 768;

  // header byte offsets
  localparam logic [6:0] HDR_DEPTH = 7'd3;
  localparam logic [6:0] HDR_XLO   = 7'd8;
  localparam logic [6:0] HDR_XHI   = 7'd9;
  localparam logic [6:0] HDR_YLO   = 7'd10;
  localparam logic [6:0] HDR_YHI   = 7'd11;
  localparam logic [6:0] HDR_LAST  = 7'(HDR_LEN - 1);

  localparam logic [9:0] PAL_LAST = 10'(PAL_LEN - 1);

  // only 8 bits per pixel is supported
  localparam logic [7:0] DEPTH_8 = 8'd8;

  // run byte marker and count mask
  localparam logic [7:0] RUN_MARK = 8'hc0;
  localparam logic [7:0] RUN_MASK = 8'h3f;

  // width of the width times height product
  localparam int PROD_W = 34;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_REQUEST = 2'd1,
    KIND_RESTART = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_PIXEL     = 2'd0,
    ST_BAD_DEPTH = 2'd1,
    ST_TOO_BIG   = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last_pixel;
    logic [16:0] image_width;
    logic [16:0] image_height;
  } out_item_t;

  // header parser to sequencer
  typedef struct packed {
    logic              last;
    logic              done;
    status_t           verdict;
    logic [15:0]       max_x;
    logic [15:0]       max_y;
    logic [PROD_W-1:0] total;
  } hdr_info_t;

endpackage

FILE: rtl/pcx_rle_palette_decoder.sv
// ----------------------------------------------------------------------------
// pcx_rle_palette_decoder
// PCX 8-bit decoder: parses the header, run-length decodes indices into a
// frame store, loads the 768-byte palette and returns RGB pixels on request.
// ----------------------------------------------------------------------------
// Steps: the last header byte waits in S_HDR for the parser's verdict, and an
// error item is then loaded through S_EMIT. A run's data byte is written out
// in S_RUN, one frame store write a cycle. A pixel request runs a frame read,
// three palette reads on the single palette read port, then the output register
// load, which waits while the output stalls. One item at a time.
// Reset clears control state only; neither store is cleared.
module pcx_rle_palette_decoder #(
  parameter int MAX_PIXELS = pcxd_pkg::MAX_PIXELS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  pcxd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pcxd_pkg::out_item_t out_data
);
  import pcxd_pkg::*;

  localparam int PW = $clog2(MAX_PIXELS + 1);
  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

  typedef enum logic [6:0] {
    PH_HEADER  = 7'b0000001,
    PH_PIXELS  = 7'b0000010,
    PH_MARKER  = 7'b0000100,
    PH_PALETTE = 7'b0001000,
    PH_DRAIN   = 7'b0010000,
    PH_ERROR   = 7'b0100000,
    PH_DONE    = 7'b1000000
  } phase_t;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_HDR  = 9'b000000010,
    S_RUN  = 9'b000000100,
    S_FRD  = 9'b000001000,
    S_PR   = 9'b000010000,
    S_PG   = 9'b000100000,
    S_PB   = 9'b001000000,
    S_PW   = 9'b010000000,
    S_EMIT = 9'b100000000
  } seq_t;

  phase_t      phase;
  seq_t        state;
  logic [PW-1:0] write_index;
  logic [PW-1:0] pixel_total;
  logic [PW-1:0] read_index;
  logic [5:0]  run_count;
  logic        run_pending;
  logic [7:0]  run_value;
  logic [9:0]  palette_count;
  logic [9:0]  pal_ptr;
  status_t     error_code;
  out_item_t   res;

  logic [7:0]  frame_mem [MAX_PIXELS];
  logic [7:0]  pal_mem [PAL_LEN];
  logic [7:0]  frame_q;
  logic [7:0]  pal_q;

  logic        accept;
  logic        is_run;
  logic        frame_we;
  logic [7:0]  frame_wdata;
  logic        pal_we;
  logic        hdr_byte_en;
  logic        restart;
  logic [16:0] img_w;
  logic [16:0] img_h;
  hdr_info_t   hdr_info;

  assign in_stall    = (state != S_IDLE);
  assign accept      = in_valid && !in_stall;
  assign is_run      = ((in_data.data_byte & RUN_MARK) == RUN_MARK);
  assign restart     = accept && (in_data.kind == KIND_RESTART);
  assign hdr_byte_en = accept && (in_data.kind == KIND_BYTE) && (phase == PH_HEADER);
  assign pal_we      = accept && (in_data.kind == KIND_BYTE) && (phase == PH_PALETTE);
  assign img_w       = {1'b0, hdr_info.max_x} + 17'd1;
  assign img_h       = {1'b0, hdr_info.max_y} + 17'd1;

  pcxd_header #(
    .MAX_PIXELS(MAX_PIXELS)
  ) u_hdr (
    .clk      (clk),
    .rst      (rst),
    .clear    (restart),
    .byte_en  (hdr_byte_en),
    .data_byte(in_data.data_byte),
    .info     (hdr_info)
  );

  // frame store write: literal byte or one step of a run
  always_comb begin
    frame_we    = 1'b0;
    frame_wdata = in_data.data_byte;
    if (accept && (in_data.kind == KIND_BYTE) && (phase == PH_PIXELS) &&
        !run_pending && !is_run && (write_index < pixel_total)) begin
      frame_we = 1'b1;
    end
    if ((state == S_RUN) && (run_count != 6'd0) && (write_index < pixel_total)) begin
      frame_we    = 1'b1;
      frame_wdata = run_value;
    end
  end

  // frame store, registered read at the read pointer
  always_ff @(posedge clk) begin
    if (frame_we) begin
      frame_mem[write_index[AW-1:0]] <= frame_wdata;
    end
    frame_q <= frame_mem[read_index[AW-1:0]];
  end

  // palette store, registered read at the palette pointer
  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[palette_count] <= in_data.data_byte;
    end
    pal_q <= pal_mem[pal_ptr];
  end

  // parse phase and sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      state         <= S_IDLE;
      write_index   <= '0;
      pixel_total   <= '0;
      read_index    <= '0;
      run_count     <= '0;
      run_pending   <= 1'b0;
      palette_count <= '0;
      error_code    <= ST_PIXEL;
      out_valid     <= 1'b0;
    end else begin
      // output register frees up when taken, unless a new item loads now
      if (out_valid && !out_stall && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_data.kind)
              KIND_RESTART: begin
                phase         <= PH_HEADER;
                write_index   <= '0;
                pixel_total   <= '0;
                read_index    <= '0;
                run_count     <= '0;
                run_pending   <= 1'b0;
                palette_count <= '0;
                error_code    <= ST_PIXEL;
              end
              KIND_BYTE: begin
                case (phase)
                  PH_HEADER: begin
                    if (hdr_info.last) begin
                      state <= S_HDR;
                    end
                  end
                  PH_PIXELS: begin
                    if (run_pending) begin
                      run_pending <= 1'b0;
                      run_value   <= in_data.data_byte;
                      state       <= S_RUN;
                    end else if (is_run) begin
                      run_count   <= 6'(in_data.data_byte & RUN_MASK);
                      run_pending <= 1'b1;
                    end else begin
                      write_index <= write_index + PW'(1);
                      if (write_index + PW'(1) >= pixel_total) begin
                        phase <= PH_MARKER;
                      end
                    end
                  end
                  PH_MARKER: begin
                    palette_count <= '0;
                    phase         <= PH_PALETTE;
                  end
                  PH_PALETTE: begin
                    palette_count <= palette_count + 10'd1;
                    if (palette_count == PAL_LAST) begin
                      read_index <= '0;
                      phase      <= PH_DRAIN;
                    end
                  end
                  default: ;
                endcase
              end
              KIND_REQUEST: begin
                if (phase == PH_ERROR) begin
                  res.status       <= error_code;
                  res.red          <= '0;
                  res.green        <= '0;
                  res.blue         <= '0;
                  res.last_pixel   <= 1'b0;
                  res.image_width  <= img_w;
                  res.image_height <= img_h;
                  state            <= S_EMIT;
                end else if ((phase == PH_DRAIN) && (read_index < pixel_total)) begin
                  res.status       <= ST_PIXEL;
                  res.last_pixel   <= (read_index + PW'(1) == pixel_total);
                  res.image_width  <= img_w;
                  res.image_height <= img_h;
                  read_index       <= read_index + PW'(1);
                  if (read_index + PW'(1) >= pixel_total) begin
                    phase <= PH_DONE;
                  end
                  state <= S_FRD;
                end
              end
              default: ;
            endcase
          end
        end
        // wait for the header verdict
        S_HDR: begin
          if (hdr_info.done) begin
            if (hdr_info.verdict != ST_PIXEL) begin
              error_code       <= hdr_info.verdict;
              phase            <= PH_ERROR;
              res.status       <= hdr_info.verdict;
              res.red          <= '0;
              res.green        <= '0;
              res.blue         <= '0;
              res.last_pixel   <= 1'b0;
              res.image_width  <= img_w;
              res.image_height <= img_h;
              state            <= S_EMIT;
            end else begin
              pixel_total <= PW'(hdr_info.total);
              write_index <= '0;
              run_pending <= 1'b0;
              phase       <= PH_PIXELS;
              state       <= S_IDLE;
            end
          end
        end
        // one run write a cycle, extra writes past the total are dropped
        S_RUN: begin
          if ((run_count != 6'd0) && (write_index < pixel_total)) begin
            write_index <= write_index + PW'(1);
            run_count   <= run_count - 6'd1;
          end else begin
            if (write_index >= pixel_total) begin
              phase <= PH_MARKER;
            end
            state <= S_IDLE;
          end
        end
        // palette base is the index times three
        S_FRD: begin
          pal_ptr <= (10'(frame_q) << 1) + 10'(frame_q);
          state   <= S_PR;
        end
        S_PR: begin
          pal_ptr <= pal_ptr + 10'd1;
          state   <= S_PG;
        end
        S_PG: begin
          res.red <= pal_q;
          pal_ptr <= pal_ptr + 10'd1;
          state   <= S_PB;
        end
        S_PB: begin
          res.green <= pal_q;
          state     <= S_PW;
        end
        S_PW: begin
          res.blue <= pal_q;
          state    <= S_EMIT;
        end
        // hand the result to the output register once it is free
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_data  <= res;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  a_write_bound: assert property (@(posedge clk) disable iff (rst)
    write_index <= pixel_total)
    else $error("write index past pixel total");

  a_frame_we_phase: assert property (@(posedge clk) disable iff (rst)
    frame_we |-> (phase == PH_PIXELS))
    else $error("frame store written outside pixel phase");

  a_palette_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PALETTE) |-> (palette_count < 10'(PAL_LEN)))
    else $error("palette count overrun");

  a_request_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_data.kind == KIND_REQUEST) && (phase == PH_DRAIN)) |=>
    (state == S_FRD))
    else $error("drain request did not start a frame read");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EMIT) && !out_valid) |=> out_valid)
    else $error("result not loaded into a free output register");

endmodule

FILE: rtl/pcxd_header.sv
// ----------------------------------------------------------------------------
// pcxd_header
// Header parser: counts the 128 header bytes, keeps bits per pixel and the
// little-endian maximum x and y, then forms the pixel total in a registered
// multiply and judges depth and size once the product is registered.
// ----------------------------------------------------------------------------
module pcxd_header #(
  parameter int MAX_PIXELS = pcxd_pkg::MAX_PIXELS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear,
  input  logic                byte_en,
  input  logic [7:0]          data_byte,
  output pcxd_pkg::hdr_info_t info
);
  import pcxd_pkg::*;

  logic [6:0]        count;
  logic [7:0]        depth;
  logic [15:0]       max_x;
  logic [15:0]       max_y;
  logic              mul_go;
  logic              chk;
  logic [PROD_W-1:0] product;
  logic [16:0]       width_c;
  logic [16:0]       height_c;
  logic [PROD_W-1:0] product_c;

  // byte capture and check sequencing
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      count  <= '0;
      depth  <= '0;
      max_x  <= '0;
      max_y  <= '0;
      mul_go <= 1'b0;
      chk    <= 1'b0;
    end else begin
      chk    <= mul_go;
      mul_go <= byte_en && (count == HDR_LAST);
      if (byte_en) begin
        case (count)
          HDR_DEPTH: depth <= data_byte;
          HDR_XLO:   max_x[7:0]  <= data_byte;
          HDR_XHI:   max_x[15:8] <= data_byte;
          HDR_YLO:   max_y[7:0]  <= data_byte;
          HDR_YHI:   max_y[15:8] <= data_byte;
          default: ;
        endcase
        count <= count + 7'd1;
      end
    end
  end

  // pixel total, one multiply then a register
  assign width_c   = {1'b0, max_x} + 17'd1;
  assign height_c  = {1'b0, max_y} + 17'd1;
  assign product_c = width_c * height_c;

  always_ff @(posedge clk) begin
    if (mul_go) begin
      product <= product_c;
    end
  end

  // verdict, depth is judged before size
  always_comb begin
    info.last  = (count == HDR_LAST);
    info.done  = chk;
    info.max_x = max_x;
    info.max_y = max_y;
    info.total = product;
    if (depth != DEPTH_8) begin
      info.verdict = ST_BAD_DEPTH;
    end else if (product > PROD_W'(MAX_PIXELS)) begin
      info.verdict = ST_TOO_BIG;
    end else begin
      info.verdict = ST_PIXEL;
    end
  end

endmodule
